// ===== hw/rtl/mfr_pkg.sv =====
// Shared types and constants for the metering frame receiver.
package mfr_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 35;
    localparam int INDEX_W     = 7;
    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_BYTES - 1);

    // Checksum seed: read command merged with the chip address
    localparam logic [7:0] READ_CMD    = 8'h50;
    localparam logic [1:0] ADDRESS_MAX = 2'd3;

    // Captured 24-bit fields and their byte offsets in the frame
    localparam int NUM_FIELDS = 5;
    localparam int FIELD_W    = 24;
    localparam logic [INDEX_W-1:0] FIELD_OFFSET [NUM_FIELDS] = '{
        7'd4, 7'd7, 7'd10, 7'd22, 7'd25
    };

    // Configuration register indexes
    localparam logic [1:0] CFG_CHIP_ADDR      = 2'd0;
    localparam logic [1:0] CFG_HEADER_VALUE   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;
    localparam logic [7:0] HEADER_RESET       = 8'h55;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_ARM  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CSUM    = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // One input item as held in the input register
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } t_item;

    // Configuration seen by the frame logic
    typedef struct packed {
        logic [1:0]  chip_addr;
        logic [7:0]  header_value;
        logic [31:0] timeout_ticks;
    } t_cfg;

endpackage

// ===== hw/rtl/mfr_cfg_regs.sv =====
// Configuration register file for the metering frame receiver.
module mfr_cfg_regs
    import mfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes, index decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chip_addr     <= '0;
            r_cfg.header_value  <= HEADER_RESET;
            r_cfg.timeout_ticks <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHIP_ADDR:     r_cfg.chip_addr     <= i_cfg_data[1:0];
                CFG_HEADER_VALUE:  r_cfg.header_value  <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/mfr_in_reg.sv =====
// Input register stage: holds one accepted item until the frame logic takes it.
module mfr_in_reg
    import mfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_in_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.op         <= i_op;
            r_item.byte_value <= i_byte_value;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/mfr_core.sv =====
// Frame parser: window, header hunt, checksum, field capture, timeout, result register.
module mfr_core
    import mfr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_take,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [FIELD_W-1:0]        o_current_a_rms,
    output logic [FIELD_W-1:0]        o_current_b_rms,
    output logic [FIELD_W-1:0]        o_voltage_rms,
    output logic signed [FIELD_W-1:0] o_energy_a_count,
    output logic signed [FIELD_W-1:0] o_energy_b_count,
    output logic [INDEX_W-1:0]        o_bytes_received
);

    // Frame state
    logic                 r_window, n_window;
    logic [INDEX_W-1:0]   r_index, n_index;
    logic [7:0]           r_sum, n_sum;
    logic [31:0]          r_elapsed, n_elapsed;
    logic [FIELD_W-1:0]   r_field [NUM_FIELDS];
    logic [FIELD_W-1:0]   n_field [NUM_FIELDS];

    // Result register
    logic                 r_out_valid;
    logic [1:0]           r_status, n_status;
    logic [FIELD_W-1:0]   r_out_field [NUM_FIELDS];
    logic [FIELD_W-1:0]   n_out_field [NUM_FIELDS];
    logic [INDEX_W-1:0]   r_bytes, n_bytes;
    logic                 n_emit;

    logic [31:0]          tick_count;
    logic [7:0]           seed;
    logic [INDEX_W-1:0]   diff [NUM_FIELDS];

    // An item is processed when the result register is free or draining
    assign o_take = i_valid && (!r_out_valid || i_out_ready);

    assign tick_count = r_elapsed + 32'd1;
    assign seed = READ_CMD | {6'b0, i_cfg.chip_addr & ADDRESS_MAX};

    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            diff[k] = r_index - FIELD_OFFSET[k];
        end
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_window  = r_window;
        n_index   = r_index;
        n_sum     = r_sum;
        n_elapsed = r_elapsed;
        n_field   = r_field;
        n_emit    = 1'b0;
        n_status  = ST_GOOD;
        n_bytes   = '0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            n_out_field[k] = '0;
        end

        case (t_op'(i_item.op))
            OP_ARM: begin
                n_window  = 1'b1;
                n_index   = '0;
                n_sum     = '0;
                n_elapsed = '0;
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    n_field[k] = '0;
                end
            end
            OP_TICK: begin
                if (r_window && (i_cfg.timeout_ticks != '0)) begin
                    n_elapsed = tick_count;
                    if (tick_count >= i_cfg.timeout_ticks) begin
                        n_emit    = 1'b1;
                        n_status  = ST_TIMEOUT;
                        n_bytes   = r_index;
                        n_window  = 1'b0;
                        n_index   = '0;
                        n_sum     = '0;
                        n_elapsed = '0;
                        for (int k = 0; k < NUM_FIELDS; k++) begin
                            n_field[k] = '0;
                        end
                    end
                end
            end
            OP_BYTE: begin
                if (r_window) begin
                    if (r_index == '0) begin
                        // Header hunt
                        if (i_item.byte_value == i_cfg.header_value) begin
                            n_sum   = seed + i_item.byte_value;
                            n_index = INDEX_W'(1);
                            for (int k = 0; k < NUM_FIELDS; k++) begin
                                n_field[k] = '0;
                            end
                        end
                    end else if (r_index < LAST_INDEX) begin
                        // Body byte: sum and capture into the matching field lane
                        n_sum   = r_sum + i_item.byte_value;
                        n_index = r_index + INDEX_W'(1);
                        for (int k = 0; k < NUM_FIELDS; k++) begin
                            if (r_index >= FIELD_OFFSET[k] && diff[k] < INDEX_W'(3)) begin
                                n_field[k][8*diff[k][1:0] +: 8] = i_item.byte_value;
                            end
                        end
                    end else begin
                        // Checksum byte closes the window
                        n_emit = 1'b1;
                        if (i_item.byte_value == ~r_sum) begin
                            n_status    = ST_GOOD;
                            n_out_field = r_field;
                        end else begin
                            n_status = ST_CSUM;
                        end
                        n_window  = 1'b0;
                        n_index   = '0;
                        n_sum     = '0;
                        n_elapsed = '0;
                        for (int k = 0; k < NUM_FIELDS; k++) begin
                            n_field[k] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= 1'b0;
            r_index   <= '0;
            r_sum     <= '0;
            r_elapsed <= '0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_field[k] <= '0;
            end
        end else if (o_take) begin
            r_window  <= n_window;
            r_index   <= n_index;
            r_sum     <= n_sum;
            r_elapsed <= n_elapsed;
            r_field   <= n_field;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take && n_emit) begin
            r_status    <= n_status;
            r_out_field <= n_out_field;
            r_bytes     <= n_bytes;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_current_a_rms  = r_out_field[0];
    assign o_current_b_rms  = r_out_field[1];
    assign o_voltage_rms    = r_out_field[2];
    assign o_energy_a_count = r_out_field[3];
    assign o_energy_b_count = r_out_field[4];
    assign o_bytes_received = r_bytes;

endmodule

// ===== hw/rtl/metering_frame_receiver_top.sv =====
// Pipeline: an accepted item is held in the input register; when the frame logic takes
// it, the item is processed and any result it closes is loaded into the output register.
// Throughput: one item per cycle; an item waits in the input register while an
// untaken result holds the output register.
// Reset (synchronous, active low): window closed, frame state cleared, header 0x55,
// address 0, timeout disabled; both pipeline registers empty.
module metering_frame_receiver_top
    import mfr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [7:0]                i_byte_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [23:0]               o_current_a_rms,
    output logic [23:0]               o_current_b_rms,
    output logic [23:0]               o_voltage_rms,
    output logic signed [23:0]        o_energy_a_count,
    output logic signed [23:0]        o_energy_b_count,
    output logic [6:0]                o_bytes_received
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  take;

    mfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mfr_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    mfr_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (item_valid),
        .i_item           (item),
        .o_take           (take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_current_a_rms  (o_current_a_rms),
        .o_current_b_rms  (o_current_b_rms),
        .o_voltage_rms    (o_voltage_rms),
        .o_energy_a_count (o_energy_a_count),
        .o_energy_b_count (o_energy_b_count),
        .o_bytes_received (o_bytes_received)
    );

endmodule

// ===== hw/rtl/mfr_checker.sv =====
// Port-level checks for the metering frame receiver, bound to the top level.
module mfr_checker
    import mfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         o_status,
    input  logic [23:0]        o_current_a_rms,
    input  logic [23:0]        o_energy_b_count,
    input  logic [6:0]         o_bytes_received
);

    // A result never carries the unused status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_GOOD || o_status == ST_CSUM
                         || o_status == ST_TIMEOUT))
        else $error("result with undefined status");

    // Frame results carry no byte count
    a_frame_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_TIMEOUT) |-> (o_bytes_received == '0))
        else $error("byte count set on a frame result");

    // Error results carry zeroed current A and energy B fields, timeouts a bounded count
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_GOOD) |->
            (o_current_a_rms == '0 && o_energy_b_count == '0
             && o_bytes_received < 7'(FRAME_BYTES)))
        else $error("error result carries frame data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind metering_frame_receiver_top mfr_checker u_mfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_current_a_rms  (o_current_a_rms),
    .o_energy_b_count (o_energy_b_count),
    .o_bytes_received (o_bytes_received)
);
